// ===== design/rwd_pkg.sv =====
package rwd_pkg;

  localparam int unsigned WORD_W        = 64;
  localparam int unsigned MARKER_W      = 32;
  localparam int unsigned ADDR_W        = 3;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned BLOCK_ID_W    = 4;
  localparam int unsigned CHANNEL_W     = 4;
  localparam int unsigned GLOBAL_CH_W   = 8;
  localparam int unsigned TIMESTAMP_W   = 26;
  localparam int unsigned OVERFLOW_W    = 15;
  localparam int unsigned TALLY_W       = 16;
  localparam int unsigned BLOCK_TALLY_W = 32;
  localparam int unsigned REPORTED_W    = 8;

  // Block id times 16 plus channel is a plain concatenation of the two nibbles
  localparam int unsigned CHANNELS_PER_BLOCK = 16;

  localparam logic [MARKER_W-1:0] HEADER_MARKER_RST  = 32'hBB1234BB;
  localparam logic [MARKER_W-1:0] TRAILER_MARKER_RST = 32'hBB4321BB;

  localparam logic KIND_EVENT   = 1'b0;
  localparam logic KIND_TRAILER = 1'b1;

  typedef enum logic {
    REG_HEADER_MARKER  = 1'b0,
    REG_TRAILER_MARKER = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    CLS_EVENT   = 2'd0,
    CLS_HEADER  = 2'd1,
    CLS_TRAILER = 2'd2
  } word_class_t;

  typedef struct packed {
    word_class_t       cls;
    logic [WORD_W-1:0] word;
  } entry_t;

endpackage

// ===== design/rwd_channels.sv =====
interface rwd_word_if;
  logic        valid;
  logic        ready;
  logic [63:0] word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface rwd_record_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] block_count;
  logic [7:0]  global_channel;
  logic [1:0]  event_kind;
  logic [25:0] coarse_time;
  logic        gain_bit;
  logic [10:0] event_number;
  logic [9:0]  charge;
  logic [9:0]  fine_time;
  logic [25:0] time_word;
  logic [7:0]  reported_channels;
  logic [15:0] counted_channels;

  modport source (
    output valid, output kind, output block_count, output global_channel,
    output event_kind, output coarse_time, output gain_bit, output event_number,
    output charge, output fine_time, output time_word, output reported_channels,
    output counted_channels, input ready
  );
  modport sink (
    input valid, input kind, input block_count, input global_channel,
    input event_kind, input coarse_time, input gain_bit, input event_number,
    input charge, input fine_time, input time_word, input reported_channels,
    input counted_channels, output ready
  );
endinterface

// ===== design/rwd_front.sv =====
module rwd_front (
  input  logic                                   clk,
  input  logic                                   rst,
  rwd_word_if.sink                               words,
  input  logic [rwd_pkg::MARKER_W-1:0]           header_marker,
  input  logic [rwd_pkg::MARKER_W-1:0]           trailer_marker,
  output logic                                   push_valid,
  output rwd_pkg::entry_t                        push_data,
  input  logic                                   push_ready
);

  logic                  stage_valid;
  rwd_pkg::entry_t       stage;
  rwd_pkg::word_class_t  cls;
  logic [rwd_pkg::MARKER_W-1:0] upper;

  assign upper = words.word[rwd_pkg::WORD_W-1 -: rwd_pkg::MARKER_W];

  // Header wins when both markers match
  always_comb begin
    if (upper == header_marker) begin
      cls = rwd_pkg::CLS_HEADER;
    end else if (upper == trailer_marker) begin
      cls = rwd_pkg::CLS_TRAILER;
    end else begin
      cls = rwd_pkg::CLS_EVENT;
    end
  end

  assign words.ready = !stage_valid || push_ready;
  assign push_valid  = stage_valid;
  assign push_data   = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (words.ready) begin
      stage_valid <= words.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (words.valid && words.ready) begin
      stage.cls  <= cls;
      stage.word <= words.word;
    end
  end

endmodule

// ===== design/rwd_queue.sv =====
module rwd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  rwd_pkg::entry_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output rwd_pkg::entry_t pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  rwd_pkg::entry_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== design/rwd_back.sv =====
module rwd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  rwd_pkg::entry_t pop_data,
  rwd_record_if.source    records
);

  logic [rwd_pkg::BLOCK_ID_W-1:0]    block_id, block_id_next;
  logic [rwd_pkg::TIMESTAMP_W-1:0]   timestamp, timestamp_next;
  logic [rwd_pkg::TALLY_W-1:0]       tally, tally_next, tally_inc;
  logic [rwd_pkg::BLOCK_TALLY_W-1:0] block_tally, block_tally_next;

  logic        out_valid;
  logic        emit;
  logic        pop;
  logic [63:0] w;

  logic        kind_r, kind_next;
  logic [31:0] block_count_r;
  logic [7:0]  global_channel_r, global_channel_next;
  logic [1:0]  event_kind_r, event_kind_next;
  logic [25:0] coarse_time_r, coarse_time_next;
  logic        gain_bit_r, gain_bit_next;
  logic [10:0] event_number_r, event_number_next;
  logic [9:0]  charge_r, charge_next;
  logic [9:0]  fine_time_r, fine_time_next;
  logic [25:0] time_word_r, time_word_next;
  logic [7:0]  reported_r, reported_next;
  logic [15:0] counted_r, counted_next;

  assign w         = pop_data.word;
  assign pop_ready = !out_valid || records.ready;
  assign pop       = pop_valid && pop_ready;

  // Saturate the per-block tally
  assign tally_inc = (tally == '1) ? tally : tally + 1'b1;

  always_comb begin
    block_id_next       = block_id;
    timestamp_next      = timestamp;
    tally_next          = tally;
    block_tally_next    = block_tally;
    emit                = 1'b0;
    kind_next           = rwd_pkg::KIND_EVENT;
    global_channel_next = '0;
    event_kind_next     = '0;
    coarse_time_next    = '0;
    gain_bit_next       = 1'b0;
    event_number_next   = '0;
    charge_next         = '0;
    fine_time_next      = '0;
    time_word_next      = '0;
    reported_next       = '0;
    counted_next        = '0;
    case (pop_data.cls)
      rwd_pkg::CLS_HEADER: begin
        block_id_next  = w[31:28];
        timestamp_next = w[25:0];
      end
      rwd_pkg::CLS_TRAILER: begin
        emit             = 1'b1;
        kind_next        = rwd_pkg::KIND_TRAILER;
        time_word_next   = 26'(w[rwd_pkg::OVERFLOW_W-1:0]);
        reported_next    = w[31:24];
        counted_next     = tally;
        tally_next       = '0;
        block_tally_next = block_tally + 1'b1;
      end
      rwd_pkg::CLS_EVENT: begin
        emit                = 1'b1;
        tally_next          = tally_inc;
        global_channel_next = {block_id, w[61:58]};
        event_kind_next     = w[63:62];
        coarse_time_next    = w[57:32];
        gain_bit_next       = w[31];
        event_number_next   = w[30:20];
        charge_next         = w[19:10];
        fine_time_next      = w[9:0];
        time_word_next      = timestamp;
        counted_next        = tally_inc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_id    <= '0;
      timestamp   <= '0;
      tally       <= '0;
      block_tally <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        block_id    <= block_id_next;
        timestamp   <= timestamp_next;
        tally       <= tally_next;
        block_tally <= block_tally_next;
      end
      if (pop_ready) begin
        out_valid <= pop_valid && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      kind_r           <= kind_next;
      block_count_r    <= block_tally;
      global_channel_r <= global_channel_next;
      event_kind_r     <= event_kind_next;
      coarse_time_r    <= coarse_time_next;
      gain_bit_r       <= gain_bit_next;
      event_number_r   <= event_number_next;
      charge_r         <= charge_next;
      fine_time_r      <= fine_time_next;
      time_word_r      <= time_word_next;
      reported_r       <= reported_next;
      counted_r        <= counted_next;
    end
  end

  assign records.valid             = out_valid;
  assign records.kind              = kind_r;
  assign records.block_count       = block_count_r;
  assign records.global_channel    = global_channel_r;
  assign records.event_kind        = event_kind_r;
  assign records.coarse_time       = coarse_time_r;
  assign records.gain_bit          = gain_bit_r;
  assign records.event_number      = event_number_r;
  assign records.charge            = charge_r;
  assign records.fine_time         = fine_time_r;
  assign records.time_word         = time_word_r;
  assign records.reported_channels = reported_r;
  assign records.counted_channels  = counted_r;

endmodule

// ===== design/readout_word_deframer.sv =====
// A word passes the classify stage, the queue and the output register before its record is valid.
// One word per cycle unless stalled; headers are absorbed in the back end and give no record.
// The queue between classifier and decoder lets either side stall without losing a cycle.
// Reset (rst, synchronous, active high) clears markers to their defaults, block id,
// timestamp, channel tally and block counter to zero, and empties all stages.
module readout_word_deframer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  rwd_word_if.sink                     words,
  rwd_record_if.source                 records,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rwd_pkg::ADDR_W-1:0]   paddr,
  input  logic [rwd_pkg::DATA_W-1:0]   pwdata,
  output logic [rwd_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  logic [rwd_pkg::MARKER_W-1:0] header_marker;
  logic [rwd_pkg::MARKER_W-1:0] trailer_marker;
  rwd_pkg::reg_index_t          reg_index;
  logic                         cfg_write;

  logic            push_valid;
  logic            push_ready;
  rwd_pkg::entry_t push_data;
  logic            pop_valid;
  logic            pop_ready;
  rwd_pkg::entry_t pop_data;

  assign pready    = 1'b1;
  assign reg_index = rwd_pkg::reg_index_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_marker  <= rwd_pkg::HEADER_MARKER_RST;
      trailer_marker <= rwd_pkg::TRAILER_MARKER_RST;
    end else if (cfg_write) begin
      case (reg_index)
        rwd_pkg::REG_HEADER_MARKER:  header_marker  <= pwdata;
        rwd_pkg::REG_TRAILER_MARKER: trailer_marker <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      rwd_pkg::REG_HEADER_MARKER:  prdata = header_marker;
      rwd_pkg::REG_TRAILER_MARKER: prdata = trailer_marker;
      default:                     prdata = '0;
    endcase
  end

  rwd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .words          (words),
    .header_marker  (header_marker),
    .trailer_marker (trailer_marker),
    .push_valid     (push_valid),
    .push_data      (push_data),
    .push_ready     (push_ready)
  );

  rwd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rwd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .records   (records)
  );

`ifndef NO_ASSERTIONS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (push_valid && !push_ready) |-> !words.ready)
    else $error("input taken while classifier stage is blocked");

  a_event_counted: assert property (@(posedge clk) disable iff (rst)
    (records.valid && records.kind == rwd_pkg::KIND_EVENT) |->
      (records.counted_channels != '0 && records.reported_channels == '0))
    else $error("event record with empty tally or reported count");

  a_trailer_clean: assert property (@(posedge clk) disable iff (rst)
    (records.valid && records.kind == rwd_pkg::KIND_TRAILER) |->
      (records.global_channel == '0 && records.coarse_time == '0 &&
       records.time_word[25:rwd_pkg::OVERFLOW_W] == '0))
    else $error("trailer record carries event fields");
`endif

endmodule

// ===== dv/readout_word_deframer_test.sv =====
`timescale 1ns / 1ps

module readout_word_deframer_test;

  localparam int CLK_HALF     = 4;
  localparam int DRAIN_CYCLES = 10;
  localparam int LONG_HOLD    = 400;
  localparam int MAX_SHOWN    = 40;

  typedef struct packed {
    logic                              kind;
    logic [rwd_pkg::BLOCK_TALLY_W-1:0] block_count;
    logic [rwd_pkg::GLOBAL_CH_W-1:0]   global_channel;
    logic [1:0]                        event_kind;
    logic [rwd_pkg::TIMESTAMP_W-1:0]   coarse_time;
    logic                              gain_bit;
    logic [10:0]                       event_number;
    logic [9:0]                        charge;
    logic [9:0]                        fine_time;
    logic [rwd_pkg::TIMESTAMP_W-1:0]   time_word;
    logic [rwd_pkg::REPORTED_W-1:0]    reported_channels;
    logic [rwd_pkg::TALLY_W-1:0]       counted_channels;
  } deframe_record_t;

  class deframe_scoreboard;
    logic [rwd_pkg::MARKER_W-1:0]      header_pattern = rwd_pkg::HEADER_MARKER_RST;
    logic [rwd_pkg::MARKER_W-1:0]      trailer_pattern = rwd_pkg::TRAILER_MARKER_RST;
    logic [rwd_pkg::BLOCK_ID_W-1:0]    block_id = '0;
    logic [rwd_pkg::TIMESTAMP_W-1:0]   timestamp = '0;
    logic [rwd_pkg::TALLY_W-1:0]       chan_tally = '0;
    logic [rwd_pkg::BLOCK_TALLY_W-1:0] blocks_seen = '0;
    deframe_record_t                   expected_records[$];
    int errors = 0;
    int checked = 0;
    int headers = 0;
    int events = 0;
    int trailers = 0;

    function void set_marker(rwd_pkg::reg_index_t idx, logic [rwd_pkg::MARKER_W-1:0] value);
      if (idx == rwd_pkg::REG_HEADER_MARKER) header_pattern = value;
      else trailer_pattern = value;
    endfunction

    function int pending();
      return expected_records.size();
    endfunction

    // Decode one accepted word; a header only updates the block context
    function void note_word(logic [rwd_pkg::WORD_W-1:0] w);
      deframe_record_t r;
      logic [rwd_pkg::MARKER_W-1:0] upper;
      upper = w[63:32];
      if (upper == header_pattern) begin
        block_id  = w[31:28];
        timestamp = w[rwd_pkg::TIMESTAMP_W-1:0];
        headers++;
        return;
      end
      r = '0;
      r.block_count = blocks_seen;
      if (upper == trailer_pattern) begin
        r.kind              = rwd_pkg::KIND_TRAILER;
        r.time_word         = rwd_pkg::TIMESTAMP_W'(w[rwd_pkg::OVERFLOW_W-1:0]);
        r.reported_channels = w[31:24];
        r.counted_channels  = chan_tally;
        chan_tally  = '0;
        blocks_seen = blocks_seen + 1'b1;
        trailers++;
      end else begin
        // saturate the per-block tally
        if (chan_tally != '1) chan_tally = chan_tally + 1'b1;
        r.kind             = rwd_pkg::KIND_EVENT;
        r.global_channel   = rwd_pkg::GLOBAL_CH_W'(block_id * rwd_pkg::CHANNELS_PER_BLOCK +
                                                   w[61:58]);
        r.event_kind       = w[63:62];
        r.coarse_time      = w[57:32];
        r.gain_bit         = w[31];
        r.event_number     = w[30:20];
        r.charge           = w[19:10];
        r.fine_time        = w[9:0];
        r.time_word        = timestamp;
        r.counted_channels = chan_tally;
        events++;
      end
      expected_records.push_back(r);
    endfunction

    function bit field_differs(string name, logic [63:0] want, logic [63:0] got);
      if (got === want) return 1'b0;
      if (errors < MAX_SHOWN)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1'b1;
    endfunction

    function void check_record(deframe_record_t got);
      deframe_record_t want;
      bit bad;
      if (expected_records.size() == 0) begin
        if (errors < MAX_SHOWN)
          $display("%0t: record with nothing expected, expected none, actual 0x%0h",
                   $time, got);
        errors++;
        return;
      end
      want = expected_records.pop_front();
      checked++;
      bad = 1'b0;
      bad |= field_differs("kind", want.kind, got.kind);
      bad |= field_differs("block_count", want.block_count, got.block_count);
      bad |= field_differs("global_channel", want.global_channel, got.global_channel);
      bad |= field_differs("event_kind", want.event_kind, got.event_kind);
      bad |= field_differs("coarse_time", want.coarse_time, got.coarse_time);
      bad |= field_differs("gain_bit", want.gain_bit, got.gain_bit);
      bad |= field_differs("event_number", want.event_number, got.event_number);
      bad |= field_differs("charge", want.charge, got.charge);
      bad |= field_differs("fine_time", want.fine_time, got.fine_time);
      bad |= field_differs("time_word", want.time_word, got.time_word);
      bad |= field_differs("reported_channels", want.reported_channels,
                           got.reported_channels);
      bad |= field_differs("counted_channels", want.counted_channels,
                           got.counted_channels);
      if (bad) errors++;
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [rwd_pkg::ADDR_W-1:0]   paddr = '0;
  logic [rwd_pkg::DATA_W-1:0]   pwdata = '0;
  logic [rwd_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  rwd_word_if   word_ch ();
  rwd_record_if rec_ch ();

  deframe_scoreboard sb = new();

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;
  int words_sent = 0;
  int marker_writes = 0;

  readout_word_deframer i_dut (
    .clk     (clk),
    .rst     (rst),
    .words   (word_ch),
    .records (rec_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #CLK_HALF clk = ~clk;

  initial begin
    word_ch.valid = 1'b0;
    word_ch.word  = '0;
  end

  // Record sink: random stall bursts plus one long hold-off on request
  initial begin
    rec_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        rec_ch.ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if ($urandom_range(0, 99) < rx_idle_pct) begin
        rec_ch.ready = 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        rec_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : record_monitor
    deframe_record_t got;
    if (!rst && rec_ch.valid === 1'b1 && rec_ch.ready === 1'b1) begin
      got.kind              = rec_ch.kind;
      got.block_count       = rec_ch.block_count;
      got.global_channel    = rec_ch.global_channel;
      got.event_kind        = rec_ch.event_kind;
      got.coarse_time       = rec_ch.coarse_time;
      got.gain_bit          = rec_ch.gain_bit;
      got.event_number      = rec_ch.event_number;
      got.charge            = rec_ch.charge;
      got.fine_time         = rec_ch.fine_time;
      got.time_word         = rec_ch.time_word;
      got.reported_channels = rec_ch.reported_channels;
      got.counted_channels  = rec_ch.counted_channels;
      sb.check_record(got);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction
  task automatic send_word(logic [rwd_pkg::WORD_W-1:0] w);
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      word_ch.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    word_ch.valid = 1'b1;
    word_ch.word  = w;
    do @(posedge clk); while (word_ch.ready !== 1'b1);
    sb.note_word(w);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    word_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_cycle(rwd_pkg::reg_index_t idx, bit is_write,
                           logic [rwd_pkg::DATA_W-1:0] wdata,
                           output logic [rwd_pkg::DATA_W-1:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = is_write;
    paddr   = {idx, 2'b00};
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_markers(logic [rwd_pkg::MARKER_W-1:0] hdr,
                             logic [rwd_pkg::MARKER_W-1:0] trl);
    logic [rwd_pkg::DATA_W-1:0] readback;
    wait_drained();
    for (int i = 0; i < 2; i++) begin
      rwd_pkg::reg_index_t idx;
      logic [rwd_pkg::MARKER_W-1:0] value;
      idx   = rwd_pkg::reg_index_t'(i);
      value = (idx == rwd_pkg::REG_HEADER_MARKER) ? hdr : trl;
      apb_cycle(idx, 1'b1, value, readback);
      sb.set_marker(idx, value);
      apb_cycle(idx, 1'b0, '0, readback);
      if (readback !== value) begin
        $display("%0t: marker %s readback mismatch, expected 0x%0h, actual 0x%0h",
                 $time, idx.name(), value, readback);
        sb.errors++;
      end
      marker_writes++;
    end
  endtask

  function automatic logic [rwd_pkg::WORD_W-1:0] random_event();
    logic [rwd_pkg::WORD_W-1:0] w;
    do w = {32'($urandom), 32'($urandom)};
    while (w[63:32] == sb.header_pattern || w[63:32] == sb.trailer_pattern);
    return w;
  endfunction

  task automatic send_block();
    int n;
    n = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 14);
    send_word({sb.header_pattern, 32'($urandom)});
    repeat (n) send_word(random_event());
    send_word({sb.trailer_pattern, 32'($urandom)});
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 4))
      0: repeat ($urandom_range(1, 4)) send_word({32'($urandom), 32'($urandom)});
      1: repeat ($urandom_range(1, 6)) send_word(random_event());
      2: send_word({sb.header_pattern, 32'($urandom)});
      3: send_word({sb.trailer_pattern, 32'($urandom)});
      // marker with one bit flipped must decode as an event
      default: send_word({sb.header_pattern ^ (32'd1 << $urandom_range(0, 31)),
                          32'($urandom)});
    endcase
  endtask

  task automatic run_phase(int n_items, int tx_pct, int rx_pct);
    int target;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    target = words_sent + n_items;
    while (words_sent < target) begin
      if ($urandom_range(0, 99) < 80) send_block();
      else send_noise();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed: events before any header, field extremes, empty block
    send_word(64'hFFFF_FFFF_FFFF_FFFF);
    send_word(64'h0);
    send_word({rwd_pkg::TRAILER_MARKER_RST, 32'hFFFF_FFFF});
    send_word({rwd_pkg::TRAILER_MARKER_RST, 32'h0});
    send_word({rwd_pkg::HEADER_MARKER_RST, 32'hFFFF_FFFF});
    for (int k = 0; k < 4; k++)
      send_word({2'(k), 4'(5 * k), 26'($urandom), 32'($urandom)});
    send_word({rwd_pkg::HEADER_MARKER_RST, 32'h0});
    send_word(64'h3C00_0000_0000_0000);
    send_word({rwd_pkg::TRAILER_MARKER_RST, 32'h8000_4000});

    // Equal markers: header takes precedence
    set_markers(32'h5A5A_5A5A, 32'h5A5A_5A5A);
    send_word({32'h5A5A_5A5A, 32'h7123_4567});
    send_word(random_event());

    set_markers(32'h0000_0000, 32'hFFFF_FFFF);
    send_word(64'h0);
    send_word({32'h0, 32'hF000_0001});
    send_word(random_event());
    send_word(64'hFFFF_FFFF_FFFF_FFFF);

    set_markers(32'hFFFF_FFFF, 32'h0000_0000);
    send_word({32'hFFFF_FFFF, 32'h9FFF_FFFF});
    send_word(random_event());
    send_word(64'h0);

    set_markers(rwd_pkg::HEADER_MARKER_RST, rwd_pkg::TRAILER_MARKER_RST);
    run_phase(240, 20, 20);

    // Hold off the record side while words keep coming
    set_markers($urandom, $urandom);
    hold_req = 1'b1;
    run_phase(240, 0, 30);

    begin
      logic [rwd_pkg::MARKER_W-1:0] same;
      same = $urandom;
      set_markers(same, same);
    end
    run_phase(120, 40, 10);
    wait_drained();
    run_phase(120, 40, 10);

    set_markers(32'h0000_0000, 32'hFFFF_FFFF);
    run_phase(240, 10, 40);

    set_markers(32'hFFFF_FFFF, 32'h0000_0000);
    run_phase(240, 25, 25);

    set_markers($urandom, $urandom);
    run_phase(240, 0, 0);

    wait_drained();
    $display("Sent %0d words (%0d headers, %0d events, %0d trailers), %0d marker writes;",
             words_sent, sb.headers, sb.events, sb.trailers, marker_writes);
    $display("checked %0d records, including equal markers and a long record stall.",
             sb.checked);
    if (sb.errors == 0) begin
      $display("[readout_word_deframer] OK");
    end else begin
      $display("[readout_word_deframer] ERROR");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("timeout with %0d records outstanding", sb.pending());
    $display("[readout_word_deframer] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
design/rwd_pkg.sv
design/rwd_channels.sv
design/rwd_front.sv
design/rwd_queue.sv
design/rwd_back.sv
design/readout_word_deframer.sv
dv/readout_word_deframer_test.sv
